### rtl/core/kmeans_2d_cluster_macros.svh
// Assertion macros for the k-means clustering block
`ifndef KMEANS_2D_CLUSTER_MACROS_SVH
`define KMEANS_2D_CLUSTER_MACROS_SVH
// same-cycle implication
`define KMC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmc assertion failed");
// next-cycle implication
`define KMC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmc assertion failed");
`endif

### rtl/core/kmc_pkg.sv
// Shared types and constants of the k-means clustering block
package kmc_pkg;
	localparam int MAX_POINTS_DEF   = 1024;
	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int COORD_BITS_DEF   = 16;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_SEED = 2'd1;
	localparam logic [1:0] MODE_RUN  = 2'd2;

	localparam logic REG_CLUSTER_COUNT   = 1'b0;
	localparam logic REG_ITERATION_COUNT = 1'b1;

	localparam logic [4:0]  CLUSTER_COUNT_RST   = 5'd2;
	localparam logic [15:0] ITERATION_COUNT_RST = 16'd300;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEED_RD, ST_SEED_WR, ST_PASS, ST_PT_RD, ST_PT_LAT, ST_SQ,
		ST_CMP, ST_ACC, ST_UPD, ST_DIV, ST_WR, ST_ITER, ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SEED_LAT, OP_SEED_RD, OP_SEED_WR, OP_RUN_INIT,
		OP_PASS_INIT, OP_PT_RD, OP_PT_LAT, OP_SQ, OP_CMP, OP_ACC, OP_UPD,
		OP_WR, OP_ITER, OP_EMIT
	} op_t;

	typedef struct packed {
		logic seed_ok;
		logic iter_zero;
		logic iter_stop;
		logic points_zero;
		logic last_point;
		logic last_cluster;
		logic cluster_empty;
		logic div_done;
	} status_t;
endpackage

### rtl/core/kmeans_2d_cluster.sv
// Top level of the 2-D Lloyd k-means clustering block
// A word is taken when start is high and busy is low. Mode 0 stores one point, so loads can
// stream at one per clock; mode 1 seeds a mean through a read and a write state; mode 2 runs
// the clustering. Each pass visits every point/mean pair on one shared squarer pair, then sets
// each mean with bit-serial dividers of W = COORD_BITS + clog2(MAX_POINTS+1) bits; an empty
// cluster skips the divide.
// Passes stop early once the means settle. The results, one per cluster, then appear back to
// back, each marked by strobe for one cycle only; the receiver cannot stall them and must take
// each as it comes. last_mean marks the final one.
module kmeans_2d_cluster #(
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
	parameter int COORD_BITS   = kmc_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic                            wr_index,
	input  logic [15:0]                     wr_data,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      mode,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	input  logic [$clog2(MAX_CLUSTERS)-1:0] seed_cluster,
	input  logic [$clog2(MAX_POINTS)-1:0]   seed_point,
	output logic                            strobe,
	output logic signed [COORD_BITS-1:0]    mean_x,
	output logic signed [COORD_BITS-1:0]    mean_y,
	output logic [$clog2(MAX_CLUSTERS)-1:0] cluster_index,
	output logic                            was_empty,
	output logic                            last_mean
);
	import kmc_pkg::*;

	op_t     op;
	status_t sts;

	kmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.op     (op),
		.busy   (busy)
	);

	kmc_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.sts           (sts),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.point_x       (point_x),
		.point_y       (point_y),
		.seed_cluster  (seed_cluster),
		.seed_point    (seed_point),
		.strobe        (strobe),
		.mean_x        (mean_x),
		.mean_y        (mean_y),
		.cluster_index (cluster_index),
		.was_empty     (was_empty),
		.last_mean     (last_mean)
	);
endmodule

### rtl/core/kmc_ram.sv
// Generic single-port RAM with registered read
module kmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### rtl/core/kmc_div.sv
// Restoring signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
module kmc_div #(
	parameter int DW = 27,
	parameter int VW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic [VW-1:0]        divisor,
	output logic                 done,
	output logic signed [DW-1:0] quotient
);
	localparam int CW = $clog2(DW);

	logic          run_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q, dv_q, rem_nxt;
	logic [DW-1:0] quo_q;
	logic [VW:0]   rem_sh;
	logic          ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DW-1]};
		ge      = rem_sh >= {1'b0, dv_q};
		rem_nxt = ge ? VW'(rem_sh - {1'b0, dv_q}) : rem_sh[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (cnt_q == CW'(DW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			rem_q <= '0;
			dv_q  <= divisor;
			neg_q <= dividend[DW-1];
			quo_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

### rtl/core/kmc_ctrl.sv
// Sequencer for load, seed and the assign/update passes of a run
module kmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  kmc_pkg::status_t  sts,
	output kmc_pkg::op_t      op,
	output logic              busy
);
	import kmc_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_SEED: state_nxt = sts.seed_ok ? ST_SEED_RD : ST_IDLE;
						MODE_RUN:  state_nxt = sts.iter_zero ? ST_EMIT : ST_PASS;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SEED_RD: state_nxt = ST_SEED_WR;
			ST_SEED_WR: state_nxt = ST_IDLE;
			ST_PASS:    state_nxt = sts.points_zero ? ST_UPD : ST_PT_RD;
			ST_PT_RD:   state_nxt = ST_PT_LAT;
			ST_PT_LAT:  state_nxt = ST_SQ;
			ST_SQ:      state_nxt = ST_CMP;
			ST_CMP:     state_nxt = sts.last_cluster ? ST_ACC : ST_SQ;
			ST_ACC:     state_nxt = sts.last_point ? ST_UPD : ST_PT_RD;
			ST_UPD: begin
				if (!sts.cluster_empty) begin
					state_nxt = ST_DIV;
				end else if (sts.last_cluster) begin
					state_nxt = ST_ITER;
				end
			end
			ST_DIV:     state_nxt = sts.div_done ? ST_WR : ST_DIV;
			ST_WR:      state_nxt = sts.last_cluster ? ST_ITER : ST_UPD;
			ST_ITER:    state_nxt = sts.iter_stop ? ST_EMIT : ST_PASS;
			ST_EMIT:    state_nxt = sts.last_cluster ? ST_IDLE : ST_EMIT;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		op   = OP_NONE;
		busy = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_LOAD: op = OP_LOAD;
						MODE_SEED: op = OP_SEED_LAT;
						MODE_RUN:  op = OP_RUN_INIT;
						default:   op = OP_NONE;
					endcase
				end
			end
			ST_SEED_RD: op = OP_SEED_RD;
			ST_SEED_WR: op = OP_SEED_WR;
			ST_PASS:    op = OP_PASS_INIT;
			ST_PT_RD:   op = OP_PT_RD;
			ST_PT_LAT:  op = OP_PT_LAT;
			ST_SQ:      op = OP_SQ;
			ST_CMP:     op = OP_CMP;
			ST_ACC:     op = OP_ACC;
			ST_UPD:     op = OP_UPD;
			ST_WR:      op = OP_WR;
			ST_ITER:    op = OP_ITER;
			ST_EMIT:    op = OP_EMIT;
			default:    op = OP_NONE;
		endcase
	end
endmodule

### rtl/core/kmc_dp.sv
// Datapath: point store, means, per-cluster sums and counts, distance and divide units
module kmc_dp #(
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
	parameter int COORD_BITS   = kmc_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kmc_pkg::op_t                      op,
	output kmc_pkg::status_t                  sts,
	input  logic                              wr_en,
	input  logic                              wr_index,
	input  logic [15:0]                       wr_data,
	input  logic signed [COORD_BITS-1:0]      point_x,
	input  logic signed [COORD_BITS-1:0]      point_y,
	input  logic [$clog2(MAX_CLUSTERS)-1:0]   seed_cluster,
	input  logic [$clog2(MAX_POINTS)-1:0]     seed_point,
	output logic                              strobe,
	output logic signed [COORD_BITS-1:0]      mean_x,
	output logic signed [COORD_BITS-1:0]      mean_y,
	output logic [$clog2(MAX_CLUSTERS)-1:0]   cluster_index,
	output logic                              was_empty,
	output logic                              last_mean
);
	import kmc_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int PTR_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CIDX_W = $clog2(MAX_CLUSTERS);
	localparam int KW     = $clog2(MAX_CLUSTERS + 1);
	localparam int SW     = C + CNT_W;
	localparam int DD_W   = 2 * C + 3;

	// configuration
	logic [4:0]  cluster_count_q;
	logic [15:0] iter_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= CLUSTER_COUNT_RST;
			iter_count_q    <= ITERATION_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CLUSTER_COUNT:   cluster_count_q <= wr_data[4:0];
				REG_ITERATION_COUNT: iter_count_q    <= wr_data;
				default:             ;
			endcase
		end
	end

	logic [KW-1:0] k;
	always_comb begin
		if (cluster_count_q == 5'd0) begin
			k = KW'(1);
		end else if (int'(cluster_count_q) > MAX_CLUSTERS) begin
			k = KW'(MAX_CLUSTERS);
		end else begin
			k = KW'(cluster_count_q);
		end
	end

	// control registers
	logic [CNT_W-1:0]  loaded_q;
	logic [PTR_W-1:0]  p_q, seed_pt_q;
	logic [CIDX_W-1:0] c_q, best_q, seed_c_q;
	logic [15:0]       iter_q;
	logic              changed_q;
	logic              empty_q [MAX_CLUSTERS];

	// payload
	logic signed [C-1:0]  mx_q [MAX_CLUSTERS];
	logic signed [C-1:0]  my_q [MAX_CLUSTERS];
	logic signed [SW-1:0] sx_q [MAX_CLUSTERS];
	logic signed [SW-1:0] sy_q [MAX_CLUSTERS];
	logic [CNT_W-1:0]     cnt_q [MAX_CLUSTERS];
	logic signed [C-1:0]  px_q, py_q;
	logic [2*C+1:0]       sqx_s1, sqy_s1;
	logic [DD_W-1:0]      best_d_q;

	// point store
	logic                 ram_we;
	logic [PTR_W-1:0]     ram_addr;
	logic [2*C-1:0]       ram_rdata;
	logic signed [C-1:0]  rd_x, rd_y;
	logic                 can_load;

	assign can_load = loaded_q < CNT_W'(MAX_POINTS);
	assign ram_we   = (op == OP_LOAD) && can_load;
	assign rd_x     = ram_rdata[2*C-1:C];
	assign rd_y     = ram_rdata[C-1:0];

	always_comb begin
		case (op)
			OP_LOAD:    ram_addr = loaded_q[PTR_W-1:0];
			OP_SEED_RD: ram_addr = seed_pt_q;
			default:    ram_addr = p_q;
		endcase
	end

	kmc_ram #(.WIDTH(2 * C), .DEPTH(MAX_POINTS)) u_pts (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({point_x, point_y}),
		.rdata (ram_rdata)
	);

	// distance of current point to mean c
	logic signed [C:0] dx, dy;
	logic [C:0]        ax, ay;
	logic [DD_W-1:0]   sq_sum;
	always_comb begin
		dx     = {mx_q[c_q][C-1], mx_q[c_q]} - {px_q[C-1], px_q};
		dy     = {my_q[c_q][C-1], my_q[c_q]} - {py_q[C-1], py_q};
		ax     = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
		ay     = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
		sq_sum = DD_W'(sqx_s1) + DD_W'(sqy_s1);
	end

	// sums and counts are indexed by the winner while accumulating, by c otherwise
	logic [CIDX_W-1:0] sidx;
	assign sidx = (op == OP_ACC) ? best_q : c_q;

	// dividers
	logic                 div_done, div_done_y;
	logic signed [SW-1:0] qx, qy;
	logic                 div_go;
	assign div_go = (op == OP_UPD) && (cnt_q[sidx] != '0);

	kmc_div #(.DW(SW), .VW(CNT_W)) u_divx (
		.clk(clk), .arst_n(arst_n), .start(div_go), .dividend(sx_q[sidx]),
		.divisor(cnt_q[sidx]), .done(div_done), .quotient(qx)
	);
	kmc_div #(.DW(SW), .VW(CNT_W)) u_divy (
		.clk(clk), .arst_n(arst_n), .start(div_go), .dividend(sy_q[sidx]),
		.divisor(cnt_q[sidx]), .done(div_done_y), .quotient(qy)
	);

	logic last_cluster;
	assign last_cluster = KW'(c_q) == k - 1'b1;

	always_comb begin
		sts.seed_ok       = (CNT_W'(seed_point) < loaded_q) &&
			(int'(seed_cluster) < MAX_CLUSTERS);
		sts.iter_zero     = iter_count_q == '0;
		sts.iter_stop     = (!changed_q && iter_q != '0) ||
			({1'b0, iter_q} + 17'd1 == {1'b0, iter_count_q});
		sts.points_zero   = loaded_q == '0;
		sts.last_point    = CNT_W'(p_q) + 1'b1 == loaded_q;
		sts.last_cluster  = last_cluster;
		sts.cluster_empty = cnt_q[sidx] == '0;
		sts.div_done      = div_done && div_done_y;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			p_q       <= '0;
			c_q       <= '0;
			best_q    <= '0;
			seed_c_q  <= '0;
			seed_pt_q <= '0;
			iter_q    <= '0;
			changed_q <= 1'b0;
			strobe    <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				empty_q[i] <= 1'b0;
			end
		end else begin
			strobe <= op == OP_EMIT;
			case (op)
				OP_LOAD: begin
					if (can_load) begin
						loaded_q <= loaded_q + 1'b1;
					end
				end
				OP_SEED_LAT: begin
					seed_c_q  <= seed_cluster;
					seed_pt_q <= seed_point;
				end
				OP_RUN_INIT: begin
					c_q    <= '0;
					iter_q <= '0;
					for (int i = 0; i < MAX_CLUSTERS; i++) begin
						empty_q[i] <= 1'b0;
					end
				end
				OP_PASS_INIT: begin
					c_q       <= '0;
					p_q       <= '0;
					changed_q <= 1'b0;
				end
				OP_CMP: begin
					if (c_q == '0 || sq_sum < best_d_q) begin
						best_q <= c_q;
					end
					if (!last_cluster) begin
						c_q <= c_q + 1'b1;
					end
				end
				OP_ACC: begin
					p_q <= p_q + 1'b1;
					c_q <= '0;
				end
				OP_UPD: begin
					empty_q[c_q] <= cnt_q[c_q] == '0;
					if (cnt_q[c_q] == '0 && !last_cluster) begin
						c_q <= c_q + 1'b1;
					end
				end
				OP_WR: begin
					if (qx[C-1:0] != mx_q[c_q] || qy[C-1:0] != my_q[c_q]) begin
						changed_q <= 1'b1;
					end
					if (!last_cluster) begin
						c_q <= c_q + 1'b1;
					end
				end
				OP_ITER: begin
					iter_q <= iter_q + 1'b1;
					c_q    <= '0;
				end
				OP_EMIT: begin
					if (!last_cluster) begin
						c_q <= c_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// means are visible state and reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				mx_q[i] <= '0;
				my_q[i] <= '0;
			end
		end else if (op == OP_SEED_WR) begin
			mx_q[seed_c_q] <= rd_x;
			my_q[seed_c_q] <= rd_y;
		end else if (op == OP_WR) begin
			mx_q[c_q] <= qx[C-1:0];
			my_q[c_q] <= qy[C-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (op)
			OP_PASS_INIT: begin
				for (int i = 0; i < MAX_CLUSTERS; i++) begin
					sx_q[i]  <= '0;
					sy_q[i]  <= '0;
					cnt_q[i] <= '0;
				end
			end
			OP_PT_LAT: begin
				px_q <= rd_x;
				py_q <= rd_y;
			end
			OP_SQ: begin
				sqx_s1 <= ax * ax;
				sqy_s1 <= ay * ay;
			end
			OP_CMP: begin
				if (c_q == '0 || sq_sum < best_d_q) begin
					best_d_q <= sq_sum;
				end
			end
			OP_ACC: begin
				sx_q[sidx]  <= sx_q[sidx] + SW'(px_q);
				sy_q[sidx]  <= sy_q[sidx] + SW'(py_q);
				cnt_q[sidx] <= cnt_q[sidx] + 1'b1;
			end
			OP_EMIT: begin
				mean_x        <= mx_q[c_q];
				mean_y        <= my_q[c_q];
				cluster_index <= c_q;
				was_empty     <= empty_q[c_q];
				last_mean     <= last_cluster;
			end
			default: ;
		endcase
	end
endmodule

### rtl/core/kmc_chk.sv
// Port-level checker for the k-means clustering block, bound to the top level
`include "kmeans_2d_cluster_macros.svh"
module kmc_chk #(
	parameter int CIDX_W = $clog2(kmc_pkg::MAX_CLUSTERS_DEF)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              strobe,
	input logic [CIDX_W-1:0] cluster_index,
	input logic              last_mean
);
	`KMC_ASSERT_NXT(a_burst_runs, strobe && !last_mean, strobe)
	`KMC_ASSERT_NXT(a_burst_ends, strobe && last_mean, !strobe)
	`KMC_ASSERT_NXT(a_index_steps, strobe && !last_mean, cluster_index == $past(cluster_index) + 1'b1)
	`KMC_ASSERT_IMP(a_burst_first, $rose(strobe), cluster_index == '0)
endmodule

bind kmeans_2d_cluster kmc_chk #(.CIDX_W($clog2(MAX_CLUSTERS))) u_kmc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.strobe        (strobe),
	.cluster_index (cluster_index),
	.last_mean     (last_mean)
);

### test/kmeans_2d_cluster_tb.sv
// Self-checking testbench for the 2-D Lloyd k-means clustering block
module kmeans_2d_cluster_tb;
	import kmc_pkg::*;

	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int NPTS = 1024;
	localparam int NCL = 16;
	localparam int WDOG_LIMIT = 200000;
	localparam int ITEM_TARGET = 300;

	typedef struct {
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic [3:0]         ci;
		logic               empty;
		logic               last;
	} mean_word_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  md;
		logic [15:0] x;
		logic [15:0] y;
		logic [3:0]  sc;
		logic [9:0]  sp;
		logic        ridx;
		logic [15:0] rdata;
		int          nfix;
		logic [15:0] fx;
		logic [15:0] fy;
		logic        fe;
	} row_t;

	logic clk, arst_n;
	logic wr_en, wr_index;
	logic [15:0] wr_data;
	logic start, busy;
	logic [1:0] mode;
	logic signed [15:0] point_x, point_y;
	logic [3:0] seed_cluster;
	logic [9:0] seed_point;
	logic strobe;
	logic signed [15:0] mean_x, mean_y;
	logic [3:0] cluster_index;
	logic was_empty, last_mean;

	kmeans_2d_cluster u_top (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.start(start), .busy(busy), .mode(mode), .point_x(point_x), .point_y(point_y),
		.seed_cluster(seed_cluster), .seed_point(seed_point), .strobe(strobe),
		.mean_x(mean_x), .mean_y(mean_y), .cluster_index(cluster_index),
		.was_empty(was_empty), .last_mean(last_mean)
	);

	// cluster model state
	longint pts_x[NPTS], pts_y[NPTS];
	int n_loaded;
	longint cen_x[NCL], cen_y[NCL];
	bit cen_empty[NCL];
	logic [4:0] k_reg;
	logic [15:0] iter_reg;

	mean_word_t mean_q[$];
	int n_err;
	int idle_cycles;
	int n_items;
	bit quiet;
	row_t rows[25];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit cluster_pass(int k);
		longint sx[NCL], sy[NCL];
		int cnt[NCL];
		longint d, bd, dx, dy, nx, ny;
		int best;
		bit moved;
		moved = 0;
		for (int c = 0; c < NCL; c++) begin
			sx[c] = 0; sy[c] = 0; cnt[c] = 0;
		end
		for (int p = 0; p < n_loaded; p++) begin
			best = 0;
			bd = 0;
			for (int c = 0; c < k; c++) begin
				dx = cen_x[c] - pts_x[p];
				dy = cen_y[c] - pts_y[p];
				d = dx * dx + dy * dy;
				if (c == 0 || d < bd) begin
					best = c;
					bd = d;
				end
			end
			sx[best] += pts_x[p];
			sy[best] += pts_y[p];
			cnt[best]++;
		end
		for (int c = 0; c < k; c++) begin
			if (cnt[c] == 0) begin
				cen_empty[c] = 1;
			end else begin
				nx = sx[c] / cnt[c];
				ny = sy[c] / cnt[c];
				cen_empty[c] = 0;
				if (nx != cen_x[c] || ny != cen_y[c]) moved = 1;
				cen_x[c] = nx;
				cen_y[c] = ny;
			end
		end
		return moved;
	endfunction

	// updates the model for one accepted word; nfix > 0 queues typed-in means instead
	task automatic model_word(logic [1:0] md, logic [15:0] x, logic [15:0] y, logic [3:0] sc,
			logic [9:0] sp, int nfix, logic [15:0] fx, logic [15:0] fy, logic fe);
		int k;
		mean_word_t w;
		case (md)
			MODE_LOAD: begin
				if (n_loaded < NPTS) begin
					pts_x[n_loaded] = longint'($signed(x));
					pts_y[n_loaded] = longint'($signed(y));
					n_loaded++;
				end
			end
			MODE_SEED: begin
				if (sp < n_loaded) begin
					cen_x[sc] = pts_x[sp];
					cen_y[sc] = pts_y[sp];
				end
			end
			MODE_RUN: begin
				k = int'(k_reg);
				if (k == 0) k = 1;
				if (k > NCL) k = NCL;
				for (int c = 0; c < NCL; c++) cen_empty[c] = 0;
				for (int it = 0; it < iter_reg; it++)
					if (!cluster_pass(k) && it > 0) break;
				for (int c = 0; c < k; c++) begin
					w.mx = (nfix > 0) ? fx : cen_x[c][15:0];
					w.my = (nfix > 0) ? fy : cen_y[c][15:0];
					w.empty = (nfix > 0) ? fe : cen_empty[c];
					w.ci = 4'(c);
					w.last = (c == k - 1);
					mean_q.push_back(w);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(logic [1:0] md, logic [15:0] x, logic [15:0] y, logic [3:0] sc,
			logic [9:0] sp, int nfix = 0, logic [15:0] fx = 0, logic [15:0] fy = 0,
			logic fe = 0);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= md;
		point_x <= x;
		point_y <= y;
		seed_cluster <= sc;
		seed_point <= sp;
		@(posedge clk);
		while (busy) @(posedge clk);
		model_word(md, x, y, sc, sp, nfix, fx, fy, fe);
		if (md != MODE_NOP) n_items++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (mean_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		drain();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_CLUSTER_COUNT) k_reg = data[4:0];
		else iter_reg = data;
	endtask

	task automatic send_rand(logic [1:0] md, logic [3:0] sc, logic [9:0] sp);
		send_word(md, 16'($urandom), 16'($urandom), sc, sp);
	endtask

	always @(posedge clk) begin
		mean_word_t w;
		if (arst_n && strobe) begin
			if (mean_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected mean word: cluster %0d", cluster_index);
			end else begin
				w = mean_q.pop_front();
				if (mean_x !== w.mx || mean_y !== w.my || cluster_index !== w.ci ||
						was_empty !== w.empty || last_mean !== w.last) begin
					n_err++;
					if (n_err <= 10)
						$display("mean mismatch: exp x=%0d y=%0d c=%0d e=%0b l=%0b, got x=%0d y=%0d c=%0d e=%0b l=%0b",
							w.mx, w.my, w.ci, w.empty, w.last,
							mean_x, mean_y, cluster_index, was_empty, last_mean);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int k_use, nl;
		arst_n <= 1'b0;
		wr_en <= 1'b0; wr_index <= 1'b0; wr_data <= '0;
		start <= 1'b0; mode <= '0; point_x <= '0; point_y <= '0;
		seed_cluster <= '0; seed_point <= '0;
		n_err = 0; n_items = 0; n_loaded = 0; quiet = 0;
		for (int c = 0; c < NCL; c++) begin
			cen_x[c] = 0; cen_y[c] = 0; cen_empty[c] = 0;
		end
		k_reg = CLUSTER_COUNT_RST;
		iter_reg = ITERATION_COUNT_RST;

		rows = '{
			'{ROW_ITEM, MODE_RUN,  16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 2, 0, 0, 1},
			'{ROW_ITEM, MODE_NOP,  16'hFFFF, 16'hFFFF, 4'd15, 10'd1023, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_SEED, 16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_LOAD, 16'h7FFF, 16'h8000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_LOAD, 16'h8000, 16'h7FFF, 4'd15, 10'd1023, 0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_LOAD, 16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_LOAD, 16'hFFFF, 16'hFFFF, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_SEED, 16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_SEED, 16'h0000, 16'h0000, 4'd1,  10'd1,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_SEED, 16'h0000, 16'h0000, 4'd15, 10'd2,    0, 0, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_SEED, 16'h0000, 16'h0000, 4'd1,  10'd1023, 0, 0, 0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_ITERATION_COUNT, 16'd0,   0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_CLUSTER_COUNT,   16'd0,   0, 0, 0, 0},
			'{ROW_ITEM, MODE_RUN,  16'h1234, 16'h5678, 4'd3,  10'd7,    0, 0, 1, 16'h7FFF,
				16'h8000, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_CLUSTER_COUNT,   16'd2,   0, 0, 0, 0},
			'{ROW_ITEM, MODE_RUN,  16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_ITERATION_COUNT, 16'd300, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_RUN,  16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_CLUSTER_COUNT,   16'hFFFF, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_RUN,  16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_CLUSTER_COUNT,   16'd1,   0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_ITERATION_COUNT, 16'hFFFF, 0, 0, 0, 0},
			'{ROW_ITEM, MODE_RUN,  16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0},
			'{ROW_CFG,  MODE_LOAD, 0, 0, 0, 0, REG_CLUSTER_COUNT,   16'd16,  0, 0, 0, 0},
			'{ROW_ITEM, MODE_RUN,  16'h0000, 16'h0000, 4'd0,  10'd0,    0, 0, 0, 0, 0, 0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_reg(rows[i].ridx, rows[i].rdata);
			else
				send_word(rows[i].md, rows[i].x, rows[i].y, rows[i].sc, rows[i].sp,
					rows[i].nfix, rows[i].fx, rows[i].fy, rows[i].fe);
		end

		// keep random runs short
		write_reg(REG_ITERATION_COUNT, 16'd4);

		// random phases: config, loads, seeds, noise, then a run
		while (n_items < ITEM_TARGET) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: write_reg(REG_CLUSTER_COUNT, 16'd16);
					1: write_reg(REG_CLUSTER_COUNT, {11'($urandom), 5'd0});
					2: write_reg(REG_CLUSTER_COUNT, 16'($urandom));
					default: write_reg(REG_CLUSTER_COUNT, 16'($urandom_range(1, 6)));
				endcase
			end
			if ($urandom_range(0, 1))
				write_reg(REG_ITERATION_COUNT, 16'($urandom_range(0, 6)));
			k_use = (k_reg == 0) ? 1 : (k_reg > NCL ? NCL : int'(k_reg));
			nl = (n_loaded < 90) ? $urandom_range(1, 5) : 0;
			repeat (nl) send_rand(MODE_LOAD, 4'($urandom), 10'($urandom));
			for (int c = 0; c < k_use; c++) begin
				if ($urandom_range(0, 7) == 0)
					send_rand(MODE_SEED, 4'($urandom), 10'($urandom_range(n_loaded, 1023)));
				else
					send_rand(MODE_SEED, 4'(c), 10'($urandom_range(0, n_loaded - 1)));
			end
			if ($urandom_range(0, 5) == 0)
				send_rand(MODE_NOP, 4'($urandom), 10'($urandom));
			send_rand(MODE_RUN, 4'($urandom), 10'($urandom));
		end

		// seed every cluster, one from an unloaded entry, then full-width runs
		quiet = 0;
		for (int c = 0; c < NCL; c++)
			send_rand(MODE_SEED, 4'(c), (c == 0) ? 10'd1023 : 10'($urandom));
		write_reg(REG_CLUSTER_COUNT, 16'd16);
		write_reg(REG_ITERATION_COUNT, 16'd1);
		send_rand(MODE_RUN, 4'($urandom), 10'($urandom));
		write_reg(REG_ITERATION_COUNT, 16'd0);
		send_rand(MODE_RUN, 4'($urandom), 10'($urandom));

		drain();
		repeat (40) @(posedge clk);
		if (n_err == 0 && mean_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
